[rtl/bfmc_pkg.sv]
// ----------------------------------------------------------------------------
// bfmc_pkg - shared types and constants for the box filter mip chain
// Pixel and pair-sum formats, handoff and result structs, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bfmc_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_LEVELS   = 12;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int CFG_W     = 13;                  // config register width
  localparam int COORD_W   = 12;                  // col / row width
  localparam int LEVEL_W   = 4;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);   // line store address
  localparam int CH_W      = 8;
  localparam int PAIR_CH_W = CH_W + 1;
  localparam int PIX_W     = 4 * CH_W;
  localparam int PAIR_W    = 4 * PAIR_CH_W;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // red in the low byte
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [PAIR_CH_W-1:0] alpha;
    logic [PAIR_CH_W-1:0] blue;
    logic [PAIR_CH_W-1:0] green;
    logic [PAIR_CH_W-1:0] red;
  } pair_t;

  typedef struct packed {
    logic   valid;
    pixel_t pixel;
  } hand_t;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pixel_t             pixel;
    logic               last;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    pair_t             data;
  } wr_t;

endpackage

`default_nettype wire

[rtl/box_filter_mip_chain_unit.sv]
// ----------------------------------------------------------------------------
// box_filter_mip_chain_unit - streaming 2x2 box-filter mip chain generator
// RGBA8 base pixels in raster order; emits every level's pixels tagged by
// level and position, lowest level first for each input beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: red, green, blue, alpha
//  m_*     | out | m_tvalid/m_tready  | tdata: col, row, rgba; tuser: level;
//          |     |                    | tlast: run_last
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (13 bits)
//
//  An input beat yields a level-0 result and one for each level above 0 that it
//  completes; the next beat is taken only once the last of them is produced.
//  One result per cycle, unless the output stalls, leaves through the single
//  output register. The level cells run one at a time; the pair-sum line RAM
//  read for the next cell is issued in the cycle before that cell fires.
//  rst is synchronous; any config write restarts the image.
//  A stalled output holds the chain where it stands; s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_mip_chain_unit
  import bfmc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [31:0]        s_tdata,    // red, green, blue, alpha
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [55:0]             m_tdata,    // col, row, red, green, blue, alpha
  output logic [LEVEL_W-1:0]      m_tuser,    // level
  output logic                    m_tlast,    // run_last
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int L = MAX_LEVELS;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             restart;
  logic             adv;
  logic             s_accept;
  logic             wave_busy;

  res_t              res_k   [L];
  wr_t               wr_k    [L];
  hand_t             hand_k  [L];
  logic [L-1:0]      casc_v;
  logic [L-1:0]      pend_v;
  logic [L-1:0]      fire_v;
  logic [L-1:0]      hand_v;
  logic [ADDR_W-1:0] look_k  [L];

  res_t              res_sel;
  wr_t               wr_sel;
  logic [ADDR_W-1:0] rd_addr;
  logic [PAIR_W-1:0] rd_data;
  res_t              out_q;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(4096);
      image_height <= CFG_W'(4096);
    end else if (restart) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0)                      w_eff = CFG_W'(1);
    else if (image_width > CFG_W'(MAX_WIDTH))   w_eff = CFG_W'(MAX_WIDTH);
    else                                        w_eff = image_width;
    if (image_height == '0)                     h_eff = CFG_W'(1);
    else if (image_height > CFG_W'(HEIGHT_LIMIT)) h_eff = CFG_W'(HEIGHT_LIMIT);
    else                                        h_eff = image_height;
  end

  assign adv       = !m_tvalid || m_tready;
  assign wave_busy = |hand_v;
  assign s_tready  = adv && !wave_busy;
  assign s_accept  = s_tvalid && s_tready;

  for (genvar k = 0; k < L; k++) begin : g_cell
    logic   cin_valid;
    pixel_t cin_pixel;

    if (k == 0) begin : g_head
      assign cin_valid = s_accept;
      assign cin_pixel = pixel_t'(s_tdata);
    end else begin : g_link
      assign cin_valid = hand_k[k-1].valid;
      assign cin_pixel = hand_k[k-1].pixel;
    end

    bfmc_level_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .restart      (restart),
      .adv          (adv),
      .in_valid     (cin_valid),
      .in_pixel     (cin_pixel),
      .level_width  (w_eff >> k),
      .level_height (h_eff >> k),
      .line_base    (ADDR_W'(MAX_WIDTH - (MAX_WIDTH >> k))),
      .level_tag    (LEVEL_W'(k)),
      .cascade_ok   (k < L - 1),
      .line_rd      (pair_t'(rd_data)),
      .res          (res_k[k]),
      .wr           (wr_k[k]),
      .hand         (hand_k[k]),
      .casc         (casc_v[k]),
      .pend         (pend_v[k]),
      .look_addr    (look_k[k])
    );

    assign fire_v[k] = res_k[k].valid;
    assign hand_v[k] = hand_k[k].valid;
  end

  // at most one cell is active, so plain priority selects are enough
  always_comb begin
    res_sel = '0;
    wr_sel  = '0;
    rd_addr = look_k[0];
    for (int k = 0; k < L; k++) begin
      if (res_k[k].valid) res_sel = res_k[k];
      if (wr_k[k].en)     wr_sel  = wr_k[k];
      if (pend_v[k])      rd_addr = look_k[k];
    end
    // fetch ahead for the cell that takes the cascade next cycle
    for (int k = 0; k < L - 1; k++) begin
      if (casc_v[k]) rd_addr = look_k[k+1];
    end
  end

  bfmc_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PAIR_W)
  ) u_lines (
    .clk   (clk),
    .we    (wr_sel.en),
    .waddr (wr_sel.addr),
    .wdata (wr_sel.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_sel.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_sel.valid) out_q <= res_sel;
  end

  assign m_tdata = {out_q.pixel.alpha, out_q.pixel.blue, out_q.pixel.green,
                    out_q.pixel.red, out_q.row, out_q.col};
  assign m_tuser = out_q.level;
  assign m_tlast = out_q.last;

`ifndef SYNTHESIS
  a_one_hand: assert property (@(posedge clk) disable iff (rst) $onehot0(hand_v))
    else $error("more than one cascade beat in flight");
  a_one_fire: assert property (@(posedge clk) disable iff (rst) $onehot0(fire_v))
    else $error("more than one level cell active");
  a_head_alone: assert property (@(posedge clk) disable iff (rst)
    fire_v[0] |-> !wave_busy)
    else $error("new input taken while a cascade is pending");
  a_casc_next: assert property (@(posedge clk) disable iff (rst || restart)
    (|casc_v) |=> wave_busy)
    else $error("cascade beat lost");
`endif

endmodule

`default_nettype wire

[rtl/bfmc_line_ram.sv]
// ----------------------------------------------------------------------------
// bfmc_line_ram - simple dual-port RAM, registered read
// One write port and one read port; read returns old data on a collision.
// ----------------------------------------------------------------------------
`default_nettype none

module bfmc_line_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 36,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/bfmc_level_cell.sv]
// ----------------------------------------------------------------------------
// bfmc_level_cell - one mip level of the filter chain
// Tracks the level's position, holds the even-column pixel, writes pair
// sums on even rows and, on an odd row and odd column, hands the averaged
// pixel to the next cell through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfmc_level_cell
  import bfmc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               restart,
  input  wire logic               adv,          // output slot free this cycle
  input  wire logic               in_valid,
  input  wire pixel_t             in_pixel,
  input  wire logic [CFG_W-1:0]   level_width,
  input  wire logic [CFG_W-1:0]   level_height,
  input  wire logic [ADDR_W-1:0]  line_base,
  input  wire logic [LEVEL_W-1:0] level_tag,
  input  wire logic               cascade_ok,
  input  wire pair_t              line_rd,
  output res_t                    res,
  output wr_t                     wr,
  output hand_t                   hand,
  output logic                    casc,
  output logic                    pend,
  output logic [ADDR_W-1:0]       look_addr
);

  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  pixel_t             held;
  logic               hand_valid;
  pixel_t             hand_pixel;

  logic               fire;
  logic               in_range;
  logic [CFG_W-1:0]   col_inc;
  logic [CFG_W-1:0]   row_inc;
  logic [COORD_W-1:0] col_next;
  logic [COORD_W-1:0] row_next;
  pair_t              pair;
  pixel_t             avg;
  logic [PAIR_CH_W:0] s_r, s_g, s_b, s_a;

  assign fire = in_valid && adv;
  assign pend = in_valid && !adv;

  // block fully inside the even-trimmed level and a next level exists
  assign in_range = cascade_ok &&
                    ((level_width >> 1) > CFG_W'(1)) &&
                    ((level_height >> 1) > CFG_W'(1)) &&
                    ({1'b0, col} < {level_width[CFG_W-1:1], 1'b0}) &&
                    ({1'b0, row} < {level_height[CFG_W-1:1], 1'b0});

  always_comb begin
    pair.red   = {1'b0, held.red}   + {1'b0, in_pixel.red};
    pair.green = {1'b0, held.green} + {1'b0, in_pixel.green};
    pair.blue  = {1'b0, held.blue}  + {1'b0, in_pixel.blue};
    pair.alpha = {1'b0, held.alpha} + {1'b0, in_pixel.alpha};
    s_r = {1'b0, line_rd.red}   + {1'b0, pair.red};
    s_g = {1'b0, line_rd.green} + {1'b0, pair.green};
    s_b = {1'b0, line_rd.blue}  + {1'b0, pair.blue};
    s_a = {1'b0, line_rd.alpha} + {1'b0, pair.alpha};
    avg.red   = s_r[PAIR_CH_W:2];
    avg.green = s_g[PAIR_CH_W:2];
    avg.blue  = s_b[PAIR_CH_W:2];
    avg.alpha = s_a[PAIR_CH_W:2];
  end

  assign casc = fire && in_range && col[0] && row[0];

  always_comb begin
    col_inc = {1'b0, col} + CFG_W'(1);
    row_inc = {1'b0, row} + CFG_W'(1);
    if (col_inc >= level_width) begin
      col_next = '0;
      row_next = (row_inc >= level_height) ? '0 : row_inc[COORD_W-1:0];
    end else begin
      col_next = col_inc[COORD_W-1:0];
      row_next = row;
    end
  end

  assign look_addr = line_base + ADDR_W'((fire ? col_next : col) >> 1);

  assign wr.en   = fire && in_range && col[0] && !row[0];
  assign wr.addr = line_base + ADDR_W'(col >> 1);
  assign wr.data = pair;

  assign res.valid = fire;
  assign res.level = level_tag;
  assign res.col   = col;
  assign res.row   = row;
  assign res.pixel = in_pixel;
  assign res.last  = !casc;

  assign hand.valid = hand_valid;
  assign hand.pixel = hand_pixel;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col        <= '0;
      row        <= '0;
      hand_valid <= 1'b0;
    end else begin
      if (fire) begin
        col <= col_next;
        row <= row_next;
      end
      if (adv) hand_valid <= casc;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_range && !col[0]) held <= in_pixel;
    if (casc) hand_pixel <= avg;
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for box_filter_mip_chain_unit
// Streams small RGBA8 images through the mip chain with random gaps and
// output stalls. Every result beat is checked against an in-bench model of
// the 2x2 box-filter cascade, or against a table entry for marked script
// rows. Image size changes happen only with the unit drained.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bfmc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;
  localparam int END_WAIT    = 20;
  localparam int RAND_ITEMS  = 76;         // random beats; with the table, about 100

  // indexes past the register list; a write still restarts the image
  localparam logic [IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_UNMAPPED_B = 2'd3;
  localparam logic [IDX_W-1:0] NO_REG         = REG_IMAGE_WIDTH;  // unused on pixel rows

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        data;
    logic               lit;   // expect a lone level-0 beat at (ecol, erow)
    logic [COORD_W-1:0] ecol;
    logic [COORD_W-1:0] erow;
  } script_row_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pixel_t             pix;
    logic               last;
  } mip_result_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [31:0]        s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [55:0]        m_tdata;
  logic [LEVEL_W-1:0] m_tuser;
  logic               m_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  box_filter_mip_chain_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // model state
  logic [CFG_W-1:0] width_reg  = 13'd4096;
  logic [CFG_W-1:0] height_reg = 13'd4096;
  pair_t            line_pair_sums [MAX_WIDTH];
  pixel_t           held_px [MAX_LEVELS];
  int unsigned      next_col [MAX_LEVELS];
  int unsigned      next_row [MAX_LEVELS];

  mip_result_t step_results [$];
  mip_result_t pending_results [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_rx = 1'b0;

  script_row_t script [32] = '{
    '{ROW_PIXEL, NO_REG,           32'h0000_0000, 1'b1, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hFFFF_FFFF, 1'b1, 12'd1, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hA5A5_A5A5, 1'b1, 12'd2, 12'd0},
    '{ROW_WRITE, REG_UNMAPPED_A,   32'h0000_1FFF, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h5A5A_5A5A, 1'b1, 12'd0, 12'd0},
    '{ROW_WRITE, REG_UNMAPPED_B,   32'h0000_0000, 1'b0, 12'd0, 12'd0},
    '{ROW_WRITE, REG_IMAGE_WIDTH,  32'h0000_0000, 1'b0, 12'd0, 12'd0},
    '{ROW_WRITE, REG_IMAGE_HEIGHT, 32'h0000_0000, 1'b0, 12'd0, 12'd0},
    // zero size acts as 1x1, so every pixel wraps back to the origin
    '{ROW_PIXEL, NO_REG,           32'h1234_5678, 1'b1, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h8765_4321, 1'b1, 12'd0, 12'd0},
    '{ROW_WRITE, REG_IMAGE_WIDTH,  32'h0000_1FFF, 1'b0, 12'd0, 12'd0},
    '{ROW_WRITE, REG_IMAGE_HEIGHT, 32'h0000_1FFF, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hFFFF_FFFF, 1'b1, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h0101_0101, 1'b1, 12'd1, 12'd0},
    '{ROW_WRITE, REG_IMAGE_WIDTH,  32'h0000_0004, 1'b0, 12'd0, 12'd0},
    '{ROW_WRITE, REG_IMAGE_HEIGHT, 32'h0000_0004, 1'b0, 12'd0, 12'd0},
    // 4x4 image: saturated block, truncating block, then mixed channels
    '{ROW_PIXEL, NO_REG,           32'hFFFF_FFFF, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hFFFF_FFFF, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h0000_0000, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h0303_0303, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hFFFF_FFFF, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hFFFF_FFFF, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h0000_0000, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h0000_0000, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h80FF_0001, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h7F00_FF02, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h1020_3040, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h5060_7080, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h01FE_7F80, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'h0001_7F80, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hC0B0_A090, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, NO_REG,           32'hF0E0_D0C0, 1'b0, 12'd0, 12'd0}
  };

  function automatic void restart_chain();
    for (int k = 0; k < MAX_LEVELS; k++) begin
      held_px[k]  = '0;
      next_col[k] = 0;
      next_row[k] = 0;
    end
  endfunction

  // Runs one base pixel down the cascade; results land in step_results.
  function automatic void mip_step(input pixel_t base);
    int unsigned      w, h, wk, hk, c, r, slot, k;
    int               ch;
    pixel_t           px, nxt;
    pair_t            pair;
    logic [PAIR_CH_W:0] quad;
    logic             carry;
    mip_result_t      res;
    step_results.delete();
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    px = base;
    k = 0;
    forever begin
      wk = w >> k;
      hk = h >> k;
      c = next_col[k];
      r = next_row[k];
      carry = 1'b0;
      res.level = LEVEL_W'(k);
      res.col = COORD_W'(c);
      res.row = COORD_W'(r);
      res.pix = px;
      // odd trailing row/column of a level never reaches the next one
      if (k + 1 < MAX_LEVELS && (wk >> 1) > 1 && (hk >> 1) > 1 &&
          c < (wk & ~32'd1) && r < (hk & ~32'd1)) begin
        if (c[0] == 1'b0) begin
          held_px[k] = px;
        end else begin
          slot = MAX_WIDTH - (MAX_WIDTH >> k) + (c >> 1);
          if (slot < MAX_WIDTH) begin
            for (ch = 0; ch < 4; ch++) begin
              pair[ch*PAIR_CH_W +: PAIR_CH_W] = held_px[k][ch*CH_W +: CH_W] + px[ch*CH_W +: CH_W];
              quad = line_pair_sums[slot][ch*PAIR_CH_W +: PAIR_CH_W] +
                     pair[ch*PAIR_CH_W +: PAIR_CH_W];
              nxt[ch*CH_W +: CH_W] = quad[PAIR_CH_W:2];
            end
            if (r[0] == 1'b0) line_pair_sums[slot] = pair;
            else carry = 1'b1;
          end
        end
      end
      c++;
      if (c >= wk) begin
        c = 0;
        r++;
        if (r >= hk) r = 0;
      end
      next_col[k] = c;
      next_row[k] = r;
      res.last = !carry;
      step_results = {step_results, res};
      if (!carry) break;
      px = nxt;
      k++;
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic idle_in(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_pixel(input pixel_t px, input logic lit,
                            input logic [COORD_W-1:0] ecol, input logic [COORD_W-1:0] erow);
    mip_result_t one;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    mip_step(px);
    if (lit) begin
      one.level = '0;
      one.col   = ecol;
      one.row   = erow;
      one.pix   = px;
      one.last  = 1'b1;
      pending_results = {pending_results, one};
    end else begin
      foreach (step_results[i]) pending_results = {pending_results, step_results[i]};
    end
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
    restart_chain();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left == 0) stall_left = gap_len();
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    mip_result_t want;
    pixel_t      got_px;
    if (!rst && m_tvalid && m_tready) begin
      got_px = pixel_t'(m_tdata[55:24]);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: level %0d col %0d row %0d",
                 $time, m_tuser, m_tdata[11:0], m_tdata[23:12]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("level", want.level, m_tuser);
        compare_field("col", want.col, m_tdata[11:0]);
        compare_field("row", want.row, m_tdata[23:12]);
        compare_field("red", want.pix.red, got_px.red);
        compare_field("green", want.pix.green, got_px.green);
        compare_field("blue", want.pix.blue, got_px.blue);
        compare_field("alpha", want.pix.alpha, got_px.alpha);
        compare_field("last", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned w, h, n, rand_items, phase;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = NO_REG;
    cfg_data  = '0;
    restart_chain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        stop_and_drain();
        write_reg(script[i].idx, script[i].data[CFG_W-1:0]);
      end else begin
        idle_in(gap_len());
        send_pixel(pixel_t'(script[i].data), script[i].lit, script[i].ecol, script[i].erow);
      end
    end

    // mostly whole images; some cut short, some run twice to cross the wrap
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      if (phase == 0) begin
        w = 4;
        h = 4;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            w = 16;
            h = 16;
          end
          1, 2, 3: begin
            w = $urandom_range(4, 9);
            h = $urandom_range(4, 9);
          end
          default: begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 7);
          end
        endcase
      end
      stop_and_drain();
      write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
      n = w * h;
      if (phase != 0) begin
        case ($urandom_range(0, 5))
          0: n = $urandom_range(1, n);
          1: n = 2 * n;
          default: ;
        endcase
      end
      quiet = (phase != 0) && ($urandom_range(0, 3) == 0);
      if (phase == 0) hold_rx = 1'b1;  // output stalls while input keeps coming
      repeat (n) begin
        if (rand_items < RAND_ITEMS) begin
          idle_in(gap_len());
          send_pixel(pick_pixel(), 1'b0, '0, '0);
          rand_items++;
        end
      end
      phase++;
    end

    stop_and_drain();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
